>>> design/opl_pkg.sv
package opl_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_LOCATE = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_POS_ERR  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // What every cell does
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         slot;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        t_mode                    mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         fill_count;
    } t_out_item;

endpackage

>>> design/opl_cell.sv
module opl_cell
    import opl_pkg::*;
(
    input  logic                     i_clk,
    input  logic [IDX_W-1:0]         i_idx,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_lower,
    input  logic signed [DATA_W-1:0] i_upper,
    output logic signed [DATA_W-1:0] o_entry,
    output logic                     o_match
);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     r_match;

    // Shift from a neighbor, take the new word, or hold
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INS: begin
                if (i_idx == i_ctl.slot) begin
                    n_entry = i_ctl.value;
                end else if (i_idx > i_ctl.slot) begin
                    n_entry = i_lower;
                end
            end
            CELL_DEL: begin
                if (i_idx >= i_ctl.slot) begin
                    n_entry = i_upper;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    // Entry and compare result are payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= (r_entry == i_ctl.value);
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

>>> design/ordered_position_list.sv
// Ordered list of up to CAPACITY signed 32-bit words, addressed by 1-based
// position. Each input item is one operation (insert, delete, get, locate)
// and yields exactly one result item with status, read value, found
// position and the fill count after the operation. The words live in a
// row of cells, one per entry, that shift toward their neighbors for
// insert and delete and compare against the search word in parallel.
// The item is latched when accepted; in the execute state the cells
// shift and register their compare, and in the finish state the match
// bits are priority-encoded and the result is loaded once the output
// register is free. The next item is accepted only once the block is
// back in its idle state, so a new item is not taken before the last
// one is finished. The result sits in an output register, so a new
// item can be accepted while it waits. Entries are not cleared at reset;
// only positions up to the fill count are ever read.
module ordered_position_list
    import opl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    t_in_item                 r_item;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] n_rd;
    logic                     r_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;

    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_entry [CAPACITY];
    logic                     w_match [CAPACITY];
    logic [CNT_W:0]           w_pos_ext;
    logic [CNT_W:0]           w_cnt_ext;
    logic                     w_pos_nz;
    logic                     w_ins_pos_ok;
    logic                     w_rd_pos_ok;
    logic                     w_full;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic [IDX_W-1:0]         w_slot;
    logic                     w_in_acc;
    logic                     w_load;
    logic [POS_W-1:0]         w_found;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // Position checks against the current fill count
    assign w_pos_ext    = (CNT_W + 1)'(r_item.position);
    assign w_cnt_ext    = (CNT_W + 1)'(r_count);
    assign w_pos_nz     = (r_item.position != '0);
    assign w_ins_pos_ok = w_pos_nz && (w_pos_ext <= w_cnt_ext + 1'b1);
    assign w_rd_pos_ok  = w_pos_nz && (w_pos_ext <= w_cnt_ext);
    assign w_full       = (w_cnt_ext >= (CNT_W + 1)'(CAPACITY));
    assign w_slot       = IDX_W'(r_item.position - 1'b1);
    assign w_ins_ok     = (r_item.mode == MODE_INSERT) && w_ins_pos_ok && !w_full;
    assign w_del_ok     = (r_item.mode == MODE_DELETE) && w_rd_pos_ok;

    // Cell control, active only in the execute cycle
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.slot  = w_slot;
        w_ctl.value = r_item.value;
        if (r_state == S_EXEC) begin
            if (w_ins_ok) begin
                w_ctl.op = CELL_INS;
            end else if (w_del_ok) begin
                w_ctl.op = CELL_DEL;
            end
        end
    end

    // Row of entry cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lower;
        logic signed [DATA_W-1:0] w_upper;
        if (g == 0) begin : g_first
            assign w_lower = r_item.value;
        end else begin : g_mid_lo
            assign w_lower = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = w_entry[g];
        end else begin : g_mid_hi
            assign w_upper = w_entry[g+1];
        end
        opl_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // First matching position among held entries
    always_comb begin
        w_found = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k] && (CNT_W'(k) < r_count)) begin
                w_found = POS_W'(k + 1);
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_EXEC;
            S_EXEC: n_state = S_FIN;
            S_FIN:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Fill count update
    always_comb begin
        n_count = r_count;
        if (r_state == S_EXEC) begin
            if (w_ins_ok) begin
                n_count = r_count + 1'b1;
            end else if (w_del_ok) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Execute-stage status and read word
    always_comb begin
        n_status = ST_OK;
        n_rd     = '0;
        case (r_item.mode) inside
            MODE_INSERT: begin
                if (!w_ins_pos_ok) begin
                    n_status = ST_POS_ERR;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            MODE_DELETE, MODE_GET: begin
                if (!w_rd_pos_ok) begin
                    n_status = ST_POS_ERR;
                end else begin
                    n_rd = w_entry[w_slot];
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // Result item as loaded into the output register
    always_comb begin
        n_out.status         = r_status;
        n_out.read_value     = r_rd;
        n_out.found_position = '0;
        n_out.fill_count     = POS_W'(r_count);
        if (r_item.mode == MODE_LOCATE) begin
            n_out.found_position = w_found;
            n_out.status         = (w_found == '0) ? ST_NOTFOUND : ST_OK;
        end
    end

    // Item latch, execute-stage result, output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_item;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_rd     <= n_rd;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_exec_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_FIN))
        else $error("execute not followed by finish");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && w_ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && w_del_ok) |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the list");

endmodule
